### rtl/core/tcq_pkg.sv
// Package for the two-class queue: field widths, entry layout and limits.
// No dependencies; imported by two_class_queue_with_starvation_limit.
package tcq_pkg;

    localparam int TICKET_W      = 16;
    localparam int TAG_W         = 32;
    localparam int ENTRY_W       = TICKET_W + TAG_W;
    localparam int RUN_W         = 4;
    localparam int QUEUE_DEPTH_D = 128;

    localparam logic [RUN_W-1:0]    RUN_MAX         = 4'd15;
    localparam logic [RUN_W-1:0]    RUN_LIMIT_RESET = 4'd2;
    localparam logic [TICKET_W-1:0] TICKET_RESET    = 16'd1;

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_SERVE   = 1'b1;

    // Registered result stage; served data comes from the memory read registers.
    typedef struct packed {
        logic                arr_ok;
        logic                rejected;
        logic                served;
        logic                from_p;
        logic                empty;
        logic [TICKET_W-1:0] issued;
    } res_t;

endpackage

### rtl/core/two_class_queue_with_starvation_limit.sv
// Two-class ticket queue with a limit on consecutive priority serves.
// Depends on tcq_pkg; holds both queue memories internally.
//
// One beat per cycle: busy stays low and start may be held high every cycle.
// Each beat gives exactly one result, shown with done high in the cycle after
// the beat is taken; served entries come from the registered read port of the
// queue memories. The receiver cannot stall; done lasts one cycle and the
// result ports hold meaningful values only while done is high. The run limit
// register may be written at any time the block is idle; it needs no clearing
// pass after reset, queue entries are only read after being written.
module two_class_queue_with_starvation_limit
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic                is_priority,
    input  logic [TAG_W-1:0]    customer_tag,
    input  logic                cfg_we,
    input  logic [RUN_W-1:0]    cfg_wdata,
    output logic                done,
    output logic [TICKET_W-1:0] ticket,
    output logic [TAG_W-1:0]    served_tag,
    output logic                served_priority,
    output logic                served_valid,
    output logic                both_empty,
    output logic                arrival_rejected
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] n_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] p_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] n_rd_reg;
    logic [ENTRY_W-1:0] p_rd_reg;

    logic [PTR_W-1:0]    n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [PTR_W-1:0]    p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [CNT_W-1:0]    n_cnt_reg, n_cnt_next, p_cnt_reg, p_cnt_next;
    logic [TICKET_W-1:0] ticket_reg, ticket_next;
    logic [RUN_W-1:0]    run_cnt_reg, run_cnt_next;
    logic [RUN_W-1:0]    limit_reg;
    logic                done_reg;
    res_t                res_reg, res_next;

    logic accept, arr, srv, has_n, has_p, full_sel, arr_ok, pick_p, pop_p, pop_n;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        ring_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign arr      = accept && (kind == KIND_ARRIVAL);
    assign srv      = accept && (kind == KIND_SERVE);
    assign has_n    = n_cnt_reg != '0;
    assign has_p    = p_cnt_reg != '0;
    assign full_sel = is_priority ? (p_cnt_reg == CNT_FULL) : (n_cnt_reg == CNT_FULL);
    assign arr_ok   = arr && !full_sel;
    assign pick_p   = has_p && !(has_n && (run_cnt_reg >= limit_reg));
    assign pop_p    = srv && pick_p;
    assign pop_n    = srv && has_n && !pick_p;

    always_comb
    begin
        n_head_next  = n_head_reg;
        n_tail_next  = n_tail_reg;
        p_head_next  = p_head_reg;
        p_tail_next  = p_tail_reg;
        n_cnt_next   = n_cnt_reg;
        p_cnt_next   = p_cnt_reg;
        ticket_next  = ticket_reg;
        run_cnt_next = run_cnt_reg;

        if (arr_ok)
        begin
            ticket_next = ticket_reg + 1'b1;
            if (is_priority)
            begin
                p_tail_next = ring_inc(p_tail_reg);
                p_cnt_next  = p_cnt_reg + 1'b1;
            end
            else
            begin
                n_tail_next = ring_inc(n_tail_reg);
                n_cnt_next  = n_cnt_reg + 1'b1;
            end
        end

        if (pop_p)
        begin
            p_head_next = ring_inc(p_head_reg);
            p_cnt_next  = p_cnt_reg - 1'b1;
            if (run_cnt_reg != RUN_MAX)
                run_cnt_next = run_cnt_reg + 1'b1;
        end

        if (pop_n)
        begin
            n_head_next  = ring_inc(n_head_reg);
            n_cnt_next   = n_cnt_reg - 1'b1;
            run_cnt_next = '0;
        end

        res_next.arr_ok   = arr_ok;
        res_next.rejected = arr && full_sel;
        res_next.served   = pop_p || pop_n;
        res_next.from_p   = pop_p;
        res_next.empty    = srv && !has_n && !has_p;
        res_next.issued   = ticket_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_head_reg  <= '0;
            n_tail_reg  <= '0;
            p_head_reg  <= '0;
            p_tail_reg  <= '0;
            n_cnt_reg   <= '0;
            p_cnt_reg   <= '0;
            ticket_reg  <= TICKET_RESET;
            run_cnt_reg <= '0;
            limit_reg   <= RUN_LIMIT_RESET;
            done_reg    <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            n_head_reg  <= n_head_next;
            n_tail_reg  <= n_tail_next;
            p_head_reg  <= p_head_next;
            p_tail_reg  <= p_tail_next;
            n_cnt_reg   <= n_cnt_next;
            p_cnt_reg   <= p_cnt_next;
            ticket_reg  <= ticket_next;
            run_cnt_reg <= run_cnt_next;
            done_reg    <= accept;
            if (accept)
                res_reg <= res_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    // Normal queue memory: write at tail, registered read at head.
    always_ff @(posedge clk)
    begin
        if (arr_ok && !is_priority)
            n_mem[n_tail_reg] <= {ticket_reg, customer_tag};
        if (pop_n)
            n_rd_reg <= n_mem[n_head_reg];
    end

    // Priority queue memory.
    always_ff @(posedge clk)
    begin
        if (arr_ok && is_priority)
            p_mem[p_tail_reg] <= {ticket_reg, customer_tag};
        if (pop_p)
            p_rd_reg <= p_mem[p_head_reg];
    end

    logic [ENTRY_W-1:0] srv_entry;

    assign srv_entry        = res_reg.from_p ? p_rd_reg : n_rd_reg;
    assign done             = done_reg;
    assign ticket           = res_reg.arr_ok ? res_reg.issued :
                              res_reg.served ? srv_entry[ENTRY_W-1:TAG_W] : '0;
    assign served_tag       = res_reg.served ? srv_entry[TAG_W-1:0] : '0;
    assign served_priority  = res_reg.served && res_reg.from_p;
    assign served_valid     = res_reg.served;
    assign both_empty       = res_reg.empty;
    assign arrival_rejected = res_reg.rejected;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done && $onehot({res_reg.arr_ok, served_valid, both_empty,
                                    arrival_rejected}))
        else $error("beat did not give exactly one result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (n_cnt_reg <= CNT_FULL) && (p_cnt_reg <= CNT_FULL))
        else $error("queue occupancy beyond depth");

    a_normal_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && served_valid && !served_priority) |-> (run_cnt_reg == '0))
        else $error("normal serve left run count set");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_n && !has_n) || (pop_p && !has_p) |-> 1'b0)
        else $error("pop from empty queue");

endmodule
